/* rtl/core/spm_pkg.sv */
// Shared constants for the stereo peak / RMS meter.
package spm_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_FRAMES_DEF  = 4096;

  // square sums and the root unit
  localparam int SUM_W  = 64;
  localparam int ROOT_W = SUM_W / 2;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(1);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_MONO  = MODE_W'(1);

  // Q2.14 gain: fraction bits and rounding half
  localparam int GAIN_FRAC = 14;
  localparam int GAIN_HALF = 1 << (GAIN_FRAC - 1);

endpackage

/* rtl/core/spm_if.sv */
// Channel interfaces of the meter: frame in, result out, configuration write.
interface spm_in_if #(parameter int SAMPLE_BITS = spm_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          last_frame;

  modport source (output valid, left_in, right_in, last_frame, input ready);
  modport sink   (input valid, left_in, right_in, last_frame, output ready);
endinterface

interface spm_out_if #(parameter int SAMPLE_BITS = spm_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          meter_valid;
  logic        [SAMPLE_BITS-2:0] peak_left;
  logic        [SAMPLE_BITS-2:0] peak_right;
  logic        [SAMPLE_BITS-2:0] rms_left;
  logic        [SAMPLE_BITS-2:0] rms_right;

  modport source (output valid, left_out, right_out, meter_valid, peak_left, peak_right,
                  rms_left, rms_right, input ready);
  modport sink   (input valid, left_out, right_out, meter_valid, peak_left, peak_right,
                  rms_left, rms_right, output ready);
endinterface

interface spm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [spm_pkg::CFG_IDX_W-1:0]      index;
  logic [spm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/spm_root_unit.sv */
// Iterative floor(sqrt(dividend / divisor)): restoring divide then digit-wise root.
module spm_root_unit #(
  parameter int CNT_W = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [spm_pkg::SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]             divisor,
  output logic                         done,
  output logic [spm_pkg::ROOT_W-1:0]   root
);
  import spm_pkg::*;

  localparam int SUB_W  = (ROOT_W + 2 > CNT_W + 1) ? ROOT_W + 2 : CNT_W + 1;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_DIV  = 3'b010,
    R_SQRT = 3'b100
  } root_state_t;

  root_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]    rad_r;
  logic [SUB_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNT_W-1:0]    div_r;
  logic [STEP_W-1:0]   step_r;
  logic                done_r;

  logic [CNT_W:0]      div_trial;
  logic [ROOT_W+1:0]   sq_trial;
  logic [SUB_W-1:0]    sub_a, sub_b;
  logic [SUB_W:0]      diff;
  logic                fits;
  logic                div_last, sqrt_last;

  // one shared compare/subtract serves both the divide and the root
  assign div_trial = {rem_r[CNT_W-1:0], rad_r[SUM_W-1]};
  assign sq_trial  = {rem_r[ROOT_W-1:0], rad_r[SUM_W-1 -: 2]};
  assign sub_a     = (state_r == R_DIV) ? SUB_W'(div_trial) : SUB_W'(sq_trial);
  assign sub_b     = (state_r == R_DIV) ? SUB_W'(div_r) : SUB_W'({root_r, 2'b01});
  assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
  assign fits      = ~diff[SUB_W];
  assign div_last  = (step_r == STEP_W'(SUM_W - 1));
  assign sqrt_last = (step_r == STEP_W'(ROOT_W - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      R_IDLE: if (start) state_nxt = R_DIV;
      R_DIV:  if (div_last) state_nxt = R_SQRT;
      R_SQRT: if (sqrt_last) state_nxt = R_IDLE;
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == R_SQRT) && sqrt_last;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          rad_r  <= dividend;
          div_r  <= divisor;
          rem_r  <= '0;
          step_r <= '0;
        end
      end
      R_DIV: begin
        // quotient bits shift in behind the dividend
        rad_r <= {rad_r[SUM_W-2:0], fits};
        if (div_last) begin
          rem_r  <= '0;
          root_r <= '0;
          step_r <= '0;
        end else begin
          rem_r  <= fits ? diff[SUB_W-1:0] : sub_a;
          step_r <= step_r + 1'b1;
        end
      end
      R_SQRT: begin
        rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
        rem_r  <= fits ? diff[SUB_W-1:0] : sub_a;
        root_r <= {root_r[ROOT_W-2:0], fits};
        step_r <= step_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* rtl/core/stereo_peak_rms_meter_top.sv */
// Stereo peak / RMS meter with master gain: sequencer, shared multiplier, accumulators.
//
//  channel   dir  handshake      carries
//  in_ch     in   valid/ready    left_in, right_in, last_frame
//  out_ch    out  valid/ready    gained samples, meter_valid, peaks, RMS values
//  cfg_ch    in   valid/ready    index, data (0 master_gain, 1 channel_mode)
//
//  An ordinary frame steps through GAIN_L, GAIN_R, SQ_L, SQ_R and ACC to FIN, where the
//  result register is loaded; no new frame is taken before the sequencer is back in idle.
//  One multiplier handles both gains and both squares in turn. A buffer-closing frame also
//  runs the root unit: divide (64 steps), then root (32 steps), for left and then for right.
//  Synchronous active-low reset; no clearing pass. in_ch is ready only in idle, also
//  while a result waits in the output register; out_ch stalls hold the sequencer at the end.
module stereo_peak_rms_meter_top #(
  parameter int SAMPLE_BITS = spm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_FRAMES  = spm_pkg::MAX_FRAMES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  spm_in_if.sink   in_ch,
  spm_out_if.source out_ch,
  spm_cfg_if.sink  cfg_ch
);
  import spm_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int MUL_B_W = (SB > GAIN_W + 1) ? SB : GAIN_W + 1;
  localparam int P_W     = SB + MUL_B_W;
  localparam int RND_W   = P_W - GAIN_FRAC;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_GAIN_L  = 11'b00000000010,
    S_GAIN_R  = 11'b00000000100,
    S_SQ_L    = 11'b00000001000,
    S_SQ_R    = 11'b00000010000,
    S_ACC     = 11'b00000100000,
    S_ROOT_LG = 11'b00001000000,
    S_ROOT_LW = 11'b00010000000,
    S_ROOT_RG = 11'b00100000000,
    S_ROOT_RW = 11'b01000000000,
    S_FIN     = 11'b10000000000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic [GAIN_W-1:0]        gain_r;
  logic [MODE_W-1:0]        mode_r;

  logic signed [SB-1:0]     sl_r, sr_r, l_r, r_r;
  logic                     last_r;
  logic signed [P_W-1:0]    prod_r;
  logic [SB-2:0]            peak_l_r, peak_r_r, rms_l_r, rms_r_r;
  logic [SUM_W-1:0]         sum_l_r, sum_r_r;
  logic [CNT_W-1:0]         frames_r, n_r;
  logic                     done_r;

  logic signed [SB-1:0]     out_left_r, out_right_r;
  logic                     out_meter_r, out_valid_r;
  logic [SB-2:0]            out_pk_l_r, out_pk_r_r, out_rms_l_r, out_rms_r_r;

  logic signed [SB-1:0]      op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [MUL_B_W-1:0] gain_op;
  logic signed [P_W-1:0]     mul_res;
  logic signed [P_W-1:0]     rnd_sum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [SB-1:0]      gained;
  logic [SUM_W-1:0]          sq_val;
  logic [CNT_W-1:0]          n_val;
  logic                      done_val;
  logic                      in_fire, out_load;
  logic                      root_start, root_done;
  logic [SUM_W-1:0]          root_in;
  logic [ROOT_W-1:0]         root_val;
  logic [SB-2:0]             root_sat;

  function automatic logic [SB-2:0] mag(input logic signed [SB-1:0] s);
    logic [SB-1:0] neg;
    neg = -s;
    if (!s[SB-1])            mag = s[SB-2:0];
    else if (s[SB-2:0] == '0) mag = '1;   // most negative sample saturates
    else                     mag = neg[SB-2:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // ---- shared multiplier ----
  assign gain_op = MUL_B_W'(signed'({1'b0, gain_r}));

  always_comb begin
    unique case (state_r)
      S_GAIN_R: begin op_a = sr_r; op_b = gain_op;          end
      S_SQ_L:   begin op_a = l_r;  op_b = MUL_B_W'(l_r);    end
      S_SQ_R:   begin op_a = r_r;  op_b = MUL_B_W'(r_r);    end
      default:  begin op_a = sl_r; op_b = gain_op;          end
    endcase
  end

  assign mul_res = op_a * op_b;

  // round half up then drop the Q2.14 fraction, clamp to the sample range
  assign rnd_sum = prod_r + P_W'(GAIN_HALF);
  assign rnd     = rnd_sum[P_W-1:GAIN_FRAC];

  always_comb begin
    if ((rnd[RND_W-1:SB-1] == '0) || (rnd[RND_W-1:SB-1] == '1))
      gained = rnd[SB-1:0];
    else
      gained = rnd[RND_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
  end

  assign sq_val   = SUM_W'($unsigned(prod_r));
  assign n_val    = frames_r + 1'b1;
  assign done_val = last_r || (n_val == CNT_W'(MAX_FRAMES));

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_load   = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);
  assign root_start = (state_r == S_ROOT_LG) || (state_r == S_ROOT_RG);
  assign root_in    = (state_r == S_ROOT_RG) ? sum_r_r : sum_l_r;
  assign root_sat   = (root_val[ROOT_W-1:SB-1] != '0) ? '1 : root_val[SB-2:0];

  spm_root_unit #(.CNT_W(CNT_W)) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .dividend (root_in),
    .divisor  (n_r),
    .done     (root_done),
    .root     (root_val)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_fire) state_nxt = S_GAIN_L;
      S_GAIN_L:  state_nxt = S_GAIN_R;
      S_GAIN_R:  state_nxt = S_SQ_L;
      S_SQ_L:    state_nxt = S_SQ_R;
      S_SQ_R:    state_nxt = S_ACC;
      S_ACC:     state_nxt = done_val ? S_ROOT_LG : S_FIN;
      S_ROOT_LG: state_nxt = S_ROOT_LW;
      S_ROOT_LW: if (root_done) state_nxt = S_ROOT_RG;
      S_ROOT_RG: state_nxt = S_ROOT_RW;
      S_ROOT_RW: if (root_done) state_nxt = S_FIN;
      S_FIN:     if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RESET;
      mode_r      <= MODE_RESET;
      peak_l_r    <= '0;
      peak_r_r    <= '0;
      sum_l_r     <= '0;
      sum_r_r     <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_GAIN: gain_r <= cfg_ch.data[GAIN_W-1:0];
          CFG_MODE: mode_r <= cfg_ch.data[MODE_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_SQ_L: if (mag(l_r) > peak_l_r) peak_l_r <= mag(l_r);
        S_SQ_R: begin
          sum_l_r <= sat_add(sum_l_r, sq_val);
          if (mag(r_r) > peak_r_r) peak_r_r <= mag(r_r);
        end
        S_ACC: begin
          sum_r_r  <= sat_add(sum_r_r, sq_val);
          frames_r <= done_val ? '0 : n_val;
        end
        S_FIN: begin
          if (out_load && done_r) begin
            peak_l_r <= '0;
            peak_r_r <= '0;
            sum_l_r  <= '0;
            sum_r_r  <= '0;
          end
        end
        default: ;
      endcase

      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sl_r   <= in_ch.left_in;
      sr_r   <= in_ch.right_in;
      last_r <= in_ch.last_frame;
    end
    if ((state_r == S_GAIN_L) || (state_r == S_GAIN_R) ||
        (state_r == S_SQ_L) || (state_r == S_SQ_R))
      prod_r <= mul_res;
    if (state_r == S_GAIN_R)
      l_r <= gained;
    if (state_r == S_SQ_L)
      r_r <= (mode_r == MODE_MONO) ? l_r : gained;
    if (state_r == S_ACC) begin
      n_r    <= n_val;
      done_r <= done_val;
    end
    if ((state_r == S_ROOT_LW) && root_done)
      rms_l_r <= root_sat;
    if ((state_r == S_ROOT_RW) && root_done)
      rms_r_r <= root_sat;
    if (out_load) begin
      out_left_r  <= l_r;
      out_right_r <= r_r;
      out_meter_r <= done_r;
      out_pk_l_r  <= done_r ? peak_l_r : '0;
      out_pk_r_r  <= done_r ? peak_r_r : '0;
      out_rms_l_r <= done_r ? rms_l_r : '0;
      out_rms_r_r <= done_r ? rms_r_r : '0;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_out    = out_left_r;
  assign out_ch.right_out   = out_right_r;
  assign out_ch.meter_valid = out_meter_r;
  assign out_ch.peak_left   = out_pk_l_r;
  assign out_ch.peak_right  = out_pk_r_r;
  assign out_ch.rms_left    = out_rms_l_r;
  assign out_ch.rms_right   = out_rms_r_r;

endmodule

/* tb/tb_stereo_peak_rms_meter_top.sv */
// Self-checking testbench for the stereo peak / RMS meter: directed table, then random buffers.
module tb_stereo_peak_rms_meter_top;
  import spm_pkg::*;

  localparam int SW         = SAMPLE_BITS_DEF;
  localparam int MAX_FRAMES = MAX_FRAMES_DEF;
  localparam longint SMP_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam logic signed [SW-1:0] S_MAX = SMP_MAX[SW-1:0];
  localparam logic signed [SW-1:0] S_MIN = SMP_MIN[SW-1:0];
  localparam logic [SW-2:0] MAG_MAX = SMP_MAX[SW-2:0];
  // items per random phase
  localparam int PHASE_ITEMS = 155;

  localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;
  localparam logic [GAIN_W-1:0] GAIN_FULL = '1;
  localparam logic [GAIN_W-1:0] GAIN_HALF_SCALE = GAIN_W'(8192);
  // mode codes 0 and 3 are undefined and behave as stereo
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = MODE_W'(3);

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 meter;
    logic [SW-2:0]        pk_l;
    logic [SW-2:0]        pk_r;
    logic [SW-2:0]        rms_l;
    logic [SW-2:0]        rms_r;
  } meter_res_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic signed [SW-1:0] l;
    logic signed [SW-1:0] r;
    logic                 last;
    bit                   typed;
    meter_res_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   mismatches;

  spm_in_if  #(.SAMPLE_BITS(SW)) in_ch();
  spm_out_if #(.SAMPLE_BITS(SW)) out_ch();
  spm_cfg_if                     cfg_ch();

  stereo_peak_rms_meter_top #(.SAMPLE_BITS(SW), .MAX_FRAMES(MAX_FRAMES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // meter model: configuration and per-buffer accumulators
  logic [GAIN_W-1:0] gain_q = GAIN_RESET;
  logic [MODE_W-1:0] mode_q = MODE_RESET;
  logic [SW-2:0]     pk_l_acc = '0;
  logic [SW-2:0]     pk_r_acc = '0;
  longint unsigned   sq_l_acc = 0;
  longint unsigned   sq_r_acc = 0;
  int                frames_in_buf = 0;

  meter_res_t due_results[$];
  stim_row_t  directed[$];

  function automatic logic signed [SW-1:0] scale(input logic signed [SW-1:0] s);
    longint p;
    // arithmetic shift gives the floor of the rounded Q2.14 product
    p = (longint'(s) * longint'(gain_q) + GAIN_HALF) >>> GAIN_FRAC;
    if (p > SMP_MAX) p = SMP_MAX;
    else if (p < SMP_MIN) p = SMP_MIN;
    return p[SW-1:0];
  endfunction

  function automatic logic [SW-2:0] mag(input logic signed [SW-1:0] s);
    longint a;
    a = longint'(s);
    if (a < 0) a = -a;
    if (a > SMP_MAX) a = SMP_MAX;
    return a[SW-2:0];
  endfunction

  function automatic longint unsigned sum_sat(input longint unsigned a, input longint unsigned b);
    longint unsigned t;
    t = a + b;
    return (t < a) ? '1 : t;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic meter_res_t predict_frame(input logic signed [SW-1:0] l_in,
                                               input logic signed [SW-1:0] r_in,
                                               input logic last);
    meter_res_t o;
    logic signed [SW-1:0] gl, gr;
    logic [SW-2:0] ml, mr;
    longint unsigned n, rl, rr;
    gl = scale(l_in);
    gr = (mode_q == MODE_MONO) ? gl : scale(r_in);
    ml = mag(gl);
    mr = mag(gr);
    if (ml > pk_l_acc) pk_l_acc = ml;
    if (mr > pk_r_acc) pk_r_acc = mr;
    sq_l_acc = sum_sat(sq_l_acc, longint'(gl) * longint'(gl));
    sq_r_acc = sum_sat(sq_r_acc, longint'(gr) * longint'(gr));
    n = frames_in_buf + 1;
    o = '0;
    o.left  = gl;
    o.right = gr;
    // a buffer reaching MAX_FRAMES closes even without the last mark
    if (last || n >= MAX_FRAMES) begin
      rl = int_sqrt(sq_l_acc / n);
      rr = int_sqrt(sq_r_acc / n);
      if (rl > SMP_MAX) rl = SMP_MAX;
      if (rr > SMP_MAX) rr = SMP_MAX;
      o.meter = 1'b1;
      o.pk_l  = pk_l_acc;
      o.pk_r  = pk_r_acc;
      o.rms_l = rl[SW-2:0];
      o.rms_r = rr[SW-2:0];
      pk_l_acc = '0;
      pk_r_acc = '0;
      sq_l_acc = 0;
      sq_r_acc = 0;
      frames_in_buf = 0;
    end else begin
      frames_in_buf = int'(n);
    end
    return o;
  endfunction

  function automatic meter_res_t res(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                                     input logic mv, input logic [SW-2:0] pl,
                                     input logic [SW-2:0] pr, input logic [SW-2:0] rl,
                                     input logic [SW-2:0] rr);
    meter_res_t o;
    o.left = l; o.right = r; o.meter = mv;
    o.pk_l = pl; o.pk_r = pr; o.rms_l = rl; o.rms_r = rr;
    return o;
  endfunction

  function automatic stim_row_t frame_row(input logic signed [SW-1:0] l,
                                          input logic signed [SW-1:0] r, input logic last);
    stim_row_t row;
    row = '{ROW_FRAME, '0, '0, l, r, last, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic signed [SW-1:0] l,
                                            input logic signed [SW-1:0] r, input logic last,
                                            input meter_res_t want);
    stim_row_t row;
    row = '{ROW_FRAME, '0, '0, l, r, last, 1'b1, want};
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{ROW_CFG, idx, data, '0, '0, 1'b0, 1'b0, '0};
    return row;
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3, 4:    return SW'($urandom_range(0, 2047)) - SW'(1024);
      default: return SW'($urandom);
    endcase
  endfunction

  // wait until every result is back; the block is idle from then on
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_GAIN) gain_q = data[GAIN_W-1:0];
    else if (idx == CFG_MODE) mode_q = data[MODE_W-1:0];
  endtask

  task automatic push_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                            input logic last, input bit typed, input meter_res_t want);
    meter_res_t p;
    while (!calm && $urandom_range(99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.left_in    <= l;
    in_ch.right_in   <= r;
    in_ch.last_frame <= last;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_frame(l, r, last);
    due_results.insert(due_results.size(), typed ? want : p);
  endtask

  always @(posedge clk) begin : result_check
    meter_res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = res(out_ch.left_out, out_ch.right_out, out_ch.meter_valid, out_ch.peak_left,
                out_ch.peak_right, out_ch.rms_left, out_ch.rms_right);
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: left %0d right %0d meter %0b", got.left, got.right,
                   got.meter);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: L %0d R %0d mv %0b pk %0d/%0d rms %0d/%0d", want.left,
                     want.right, want.meter, want.pk_l, want.pk_r, want.rms_l, want.rms_r);
            $display("         got: L %0d R %0d mv %0b pk %0d/%0d rms %0d/%0d", got.left,
                     got.right, got.meter, got.pk_l, got.pk_r, got.rms_l, got.rms_r);
          end
        end
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 36);
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [GAIN_W-1:0] g;
    logic [MODE_W-1:0] m;
    int sent, len;

    rst_n = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    in_ch.last_frame = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_GAIN;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;

    // unity gain, stereo after reset
    add_row(checked_row('0, '0, 1'b1, res('0, '0, 1'b1, '0, '0, '0, '0)));
    add_row(checked_row(S_MAX, S_MIN, 1'b1,
                        res(S_MAX, S_MIN, 1'b1, MAG_MAX, MAG_MAX, MAG_MAX, MAG_MAX)));
    add_row(checked_row(SW'(123), -SW'(456), 1'b0,
                        res(SW'(123), -SW'(456), 1'b0, '0, '0, '0, '0)));
    add_row(frame_row(-SW'(1), SW'(1), 1'b0));
    add_row(frame_row(SW'(1000), -SW'(2000), 1'b1));
    add_row(reg_row(CFG_GAIN, GAIN_ZERO));
    add_row(checked_row(S_MAX, S_MIN, 1'b1, res('0, '0, 1'b1, '0, '0, '0, '0)));
    add_row(reg_row(CFG_GAIN, GAIN_FULL));
    add_row(checked_row(S_MAX, S_MIN, 1'b0, res(S_MAX, S_MIN, 1'b0, '0, '0, '0, '0)));
    add_row(frame_row(SW'(4096), -SW'(4096), 1'b1));
    // half gain: rounding at the halfway point
    add_row(reg_row(CFG_GAIN, GAIN_HALF_SCALE));
    add_row(frame_row(SW'(3), -SW'(3), 1'b0));
    add_row(frame_row(SW'(1), -SW'(1), 1'b1));
    add_row(reg_row(CFG_MODE, CFG_DATA_W'(MODE_MONO)));
    add_row(reg_row(CFG_GAIN, GAIN_RESET));
    add_row(checked_row(SW'(500), -SW'(7777), 1'b0,
                        res(SW'(500), SW'(500), 1'b0, '0, '0, '0, '0)));
    add_row(frame_row(-SW'(300), S_MAX, 1'b1));
    add_row(reg_row(CFG_MODE, CFG_DATA_W'(MODE_SPARE_LO)));
    add_row(frame_row(SW'(10), -SW'(20), 1'b1));
    add_row(reg_row(CFG_MODE, CFG_DATA_W'(MODE_SPARE_HI)));
    add_row(frame_row(S_MIN, S_MAX, 1'b1));
    add_row(reg_row(CFG_MODE, CFG_DATA_W'(MODE_RESET)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_reg(directed[i].idx, directed[i].data);
      else
        push_frame(directed[i].l, directed[i].r, directed[i].last, directed[i].typed,
                   directed[i].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 5);
      case (ph % 4)
        0:       m = MODE_RESET;
        1:       m = MODE_MONO;
        2:       m = MODE_SPARE_LO;
        default: m = MODE_SPARE_HI;
      endcase
      if (ph == 0) g = GAIN_RESET;
      else if (ph == 1) g = GAIN_FULL;
      else if (ph == 2) g = GAIN_ZERO;
      else if ($urandom_range(0, 1)) g = GAIN_W'($urandom);
      else g = GAIN_W'($urandom_range(12000, 24000));
      write_reg(CFG_GAIN, CFG_DATA_W'(g));
      write_reg(CFG_MODE, CFG_DATA_W'(m));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0:          len = $urandom_range(100, 300);
          1, 2, 3, 4: len = 1;
          default:    len = $urandom_range(2, 16);
        endcase
        if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
        for (int k = 0; k < len; k++)
          push_frame(pick_sample(), pick_sample(), k == len - 1, 1'b0, '0);
        sent += len;
      end
    end
    calm = 1'b0;

    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* stereo_peak_rms_meter_top.f */
rtl/core/spm_pkg.sv
rtl/core/spm_if.sv
rtl/core/spm_root_unit.sv
rtl/core/stereo_peak_rms_meter_top.sv
tb/tb_stereo_peak_rms_meter_top.sv
